// ----- rtl/assert_macros.svh -----
// Assertion macros shared by the address unit RTL.
// No dependencies; define ASSERT_OFF to compile the checks out.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define ASSERT_NEVER(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(prop)) else $error(msg);
`else
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg)
`define ASSERT_NEVER(label, clk, rst_n, prop, msg)
`endif
`endif

// ----- rtl/e2c_pkg.sv -----
// Types, constants and the sine table for the equirect-to-cubemap address unit.
// No dependencies.
`timescale 1ns / 1ps
package e2c_pkg;

  localparam int unsigned PANO_WIDTH  = 2048;
  localparam int unsigned PANO_HEIGHT = 1024;
  localparam int unsigned FACE_WIDTH  = 512;
  localparam int unsigned FACE_HEIGHT = 512;
  localparam int unsigned DIV_STAGES  = 16;

  localparam logic [15:0] SINE_TAB [65] = '{
    16'd0,     16'd804,   16'd1608,  16'd2411,  16'd3212,  16'd4011,  16'd4808,  16'd5602,
    16'd6393,  16'd7180,  16'd7962,  16'd8740,  16'd9512,  16'd10279, 16'd11039, 16'd11793,
    16'd12540, 16'd13279, 16'd14010, 16'd14733, 16'd15447, 16'd16151, 16'd16846, 16'd17531,
    16'd18205, 16'd18868, 16'd19520, 16'd20160, 16'd20788, 16'd21403, 16'd22006, 16'd22595,
    16'd23170, 16'd23732, 16'd24279, 16'd24812, 16'd25330, 16'd25833, 16'd26320, 16'd26791,
    16'd27246, 16'd27684, 16'd28106, 16'd28511, 16'd28899, 16'd29269, 16'd29622, 16'd29957,
    16'd30274, 16'd30572, 16'd30853, 16'd31114, 16'd31357, 16'd31581, 16'd31786, 16'd31972,
    16'd32138, 16'd32286, 16'd32413, 16'd32522, 16'd32610, 16'd32679, 16'd32729, 16'd32758,
    16'd32767
  };

  typedef enum logic [2:0] {
    FACE_RIGHT = 3'd0,
    FACE_LEFT  = 3'd1,
    FACE_UP    = 3'd2,
    FACE_DOWN  = 3'd3,
    FACE_FRONT = 3'd4,
    FACE_BACK  = 3'd5
  } face_e;

  typedef struct packed {
    logic [10:0] column;
    logic [9:0]  row;
  } e2c_in_t;

  typedef struct packed {
    logic [2:0] face;
    logic [8:0] face_x;
    logic [8:0] face_y;
  } e2c_out_t;

  // Per-item control that rides alongside the divider.
  typedef struct packed {
    face_e face;
    logic  inv_x;   // use 32768 - q for face_x
    logic  inv_y;   // use 32768 - q for face_y
    logic  flip_y;  // face_y = FACE_HEIGHT-1 - coord
  } e2c_side_t;

  typedef struct packed {
    logic [15:0] mag_x;
    logic [15:0] mag_y;
    logic [14:0] divisor;
    e2c_side_t   side;
  } e2c_div_in_t;

  typedef struct packed {
    logic [15:0] quo_x;
    logic [15:0] quo_y;
    e2c_side_t   side;
  } e2c_div_out_t;

  typedef struct packed {
    logic [15:0] base;
    logic [9:0]  delta;
    logic [7:0]  frac;
    logic        neg;
  } sin_pre_t;

  // Quarter-wave fold and table read for one phase.
  function automatic sin_pre_t sin_pre(logic [15:0] ph);
    logic [14:0] p;
    logic [6:0]  idx;
    sin_pre_t    r;
    p = ph[14] ? (15'h4000 - {1'b0, ph[13:0]}) : {1'b0, ph[13:0]};
    idx    = p[14:8];
    r.frac = p[7:0];
    r.neg  = ph[15];
    if (idx >= 7'd64) begin
      r.base  = SINE_TAB[64];
      r.delta = '0;
    end else begin
      r.base  = SINE_TAB[idx];
      r.delta = 10'(SINE_TAB[7'(idx + 7'd1)] - SINE_TAB[idx]);
    end
    return r;
  endfunction

endpackage

// ----- rtl/e2c_div.sv -----
// Pipelined restoring divider, two lanes sharing one divisor, one quotient bit per stage.
// Depends on e2c_pkg.
`timescale 1ns / 1ps
module e2c_div
  import e2c_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         en_i,
  input  logic         valid_i,
  input  e2c_div_in_t  din_i,
  output logic         valid_o,
  output e2c_div_out_t dout_o
);

  logic        v_q   [DIV_STAGES];
  logic [14:0] rx_q  [DIV_STAGES];
  logic [14:0] ry_q  [DIV_STAGES];
  logic [15:0] qx_q  [DIV_STAGES];
  logic [15:0] qy_q  [DIV_STAGES];
  logic [14:0] dv_q  [DIV_STAGES];
  e2c_side_t   sd_q  [DIV_STAGES];

  // Magnitude never exceeds the divisor, so the top bit is an equality test.
  logic        bx0, by0;
  assign bx0 = (din_i.mag_x >= {1'b0, din_i.divisor});
  assign by0 = (din_i.mag_y >= {1'b0, din_i.divisor});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q[0] <= 1'b0;
    end else if (en_i) begin
      v_q[0] <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rx_q[0] <= 15'(din_i.mag_x - (bx0 ? {1'b0, din_i.divisor} : 16'd0));
      ry_q[0] <= 15'(din_i.mag_y - (by0 ? {1'b0, din_i.divisor} : 16'd0));
      qx_q[0] <= {15'd0, bx0};
      qy_q[0] <= {15'd0, by0};
      dv_q[0] <= din_i.divisor;
      sd_q[0] <= din_i.side;
    end
  end

  for (genvar k = 1; k < DIV_STAGES; k++) begin : g_stage
    logic [15:0] sx, sy;
    logic        bx, by;
    assign sx = {rx_q[k-1], 1'b0};
    assign sy = {ry_q[k-1], 1'b0};
    assign bx = (sx >= {1'b0, dv_q[k-1]});
    assign by = (sy >= {1'b0, dv_q[k-1]});

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[k] <= 1'b0;
      end else if (en_i) begin
        v_q[k] <= v_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rx_q[k] <= 15'(sx - (bx ? {1'b0, dv_q[k-1]} : 16'd0));
        ry_q[k] <= 15'(sy - (by ? {1'b0, dv_q[k-1]} : 16'd0));
        qx_q[k] <= {qx_q[k-1][14:0], bx};
        qy_q[k] <= {qy_q[k-1][14:0], by};
        dv_q[k] <= dv_q[k-1];
        sd_q[k] <= sd_q[k-1];
      end
    end
  end

  assign valid_o      = v_q[DIV_STAGES-1];
  assign dout_o.quo_x = qx_q[DIV_STAGES-1];
  assign dout_o.quo_y = qy_q[DIV_STAGES-1];
  assign dout_o.side  = sd_q[DIV_STAGES-1];

endmodule

// ----- rtl/equirect_to_cubemap_address_unit.sv -----
// Top level of the equirect-to-cubemap address unit.
// Depends on e2c_pkg, e2c_div and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"
// Usage:
//   Input channel (in_valid_i / in_stall_o / in_data_i) carries one panorama
//   pixel (column, row) per item. Output channel (out_valid_o / out_stall_i /
//   out_data_o) returns one item per input: cube face and texel x, y.
//   An item moves on a rising edge where valid is high and stall is low.
// Pipeline:
//   4 front stages (sine table fold, interpolation, vector products, face
//   select), 16 divider stages at one quotient bit each, and one coordinate
//   stage that is also the output register.
//   One item per clock is sustained while out_stall_i does not hold the pipeline.
// Reset:
//   rst_ni clears every valid bit at once; the pipeline comes up empty and
//   ready, no clearing pass.
// Stall:
//   While the output item waits under out_stall_i, the whole pipeline holds
//   and in_stall_o rises in the same cycle; no item is lost or repeated.
//   Bubbles ahead of the output register keep flowing whenever it is free.
module equirect_to_cubemap_address_unit
  import e2c_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_stall_o,
  input  e2c_in_t  in_data_i,
  output logic     out_valid_o,
  input  logic     out_stall_i,
  output e2c_out_t out_data_o
);

  logic en;
  logic out_valid_q;

  // Hold everything only when the output register is full and blocked.
  assign en         = !(out_valid_q && out_stall_i);
  assign in_stall_o = !en;

  // ---------------- Stage 1: phases and table reads ----------------
  logic [15:0] phi, th;
  assign phi = 16'(({in_data_i.column, 16'd0}) / PANO_WIDTH);
  assign th  = 16'(32'd32768 - 32'(({in_data_i.row, 15'd0}) / PANO_HEIGHT));

  logic     s1_v_q;
  sin_pre_t s1_sp_q, s1_cp_q, s1_st_q, s1_ct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s1_sp_q <= sin_pre(phi);
      s1_cp_q <= sin_pre(16'(phi + 16'h4000));
      s1_st_q <= sin_pre(th);
      s1_ct_q <= sin_pre(16'(th + 16'h4000));
    end
  end

  // ---------------- Stage 2: interpolate sines ----------------
  function automatic logic signed [16:0] sin_fin(sin_pre_t s);
    logic [17:0] prod;
    logic [15:0] v;
    prod = s.delta * s.frac;
    v    = 16'(s.base + {6'd0, prod[17:8]});
    return s.neg ? -$signed({1'b0, v}) : $signed({1'b0, v});
  endfunction

  logic               s2_v_q;
  logic signed [16:0] s2_sp_q, s2_cp_q, s2_st_q, s2_ct_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q <= 1'b0;
    end else if (en) begin
      s2_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s2_sp_q <= sin_fin(s1_sp_q);
      s2_cp_q <= sin_fin(s1_cp_q);
      s2_st_q <= sin_fin(s1_st_q);
      s2_ct_q <= sin_fin(s1_ct_q);
    end
  end

  // ---------------- Stage 3: direction vector ----------------
  // Q1.15 product rounded half up is a floor shift of p + 16384.
  function automatic logic signed [16:0] mul_q15(logic signed [16:0] a,
                                                 logic signed [16:0] b);
    logic signed [33:0] p;
    p = a * b + 34'sd16384;
    return 17'(p >>> 15);
  endfunction

  logic               s3_v_q;
  logic signed [16:0] s3_x_q, s3_y_q, s3_z_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_v_q <= 1'b0;
    end else if (en) begin
      s3_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s3_x_q <= -mul_q15(s2_sp_q, s2_st_q);
      s3_y_q <= s2_ct_q;
      s3_z_q <= -mul_q15(s2_cp_q, s2_st_q);
    end
  end

  // ---------------- Stage 4: face select ----------------
  logic [15:0] ax, ay, az, amax, adiv;
  assign ax = 16'(s3_x_q[16] ? -s3_x_q : s3_x_q);
  assign ay = 16'(s3_y_q[16] ? -s3_y_q : s3_y_q);
  assign az = 16'(s3_z_q[16] ? -s3_z_q : s3_z_q);

  always_comb begin
    amax = ax;
    if (ay > amax) amax = ay;
    if (az > amax) amax = az;
    adiv = (amax == 16'd0) ? 16'd1 : amax;
  end

  e2c_div_in_t div_in;
  logic        xpos, xneg, ypos, yneg, zpos;
  assign xpos = !s3_x_q[16] && (s3_x_q != 17'sd0);
  assign xneg = s3_x_q[16];
  assign ypos = !s3_y_q[16] && (s3_y_q != 17'sd0);
  assign yneg = s3_y_q[16];
  assign zpos = !s3_z_q[16] && (s3_z_q != 17'sd0);

  // Ties resolve right, left, up, down, front, back.
  always_comb begin
    div_in.divisor     = adiv[14:0];
    div_in.side.flip_y = 1'b0;
    div_in.side.inv_y  = yneg;
    div_in.mag_y       = ay;
    if (ax == adiv && xpos) begin
      div_in.side.face  = FACE_RIGHT;
      div_in.mag_x      = az;
      div_in.side.inv_x = !s3_z_q[16];
    end else if (ax == adiv && xneg) begin
      div_in.side.face  = FACE_LEFT;
      div_in.mag_x      = az;
      div_in.side.inv_x = s3_z_q[16];
    end else if (ay == adiv && yneg) begin
      div_in.side.face   = FACE_UP;
      div_in.mag_x       = ax;
      div_in.side.inv_x  = s3_x_q[16];
      div_in.mag_y       = az;
      div_in.side.inv_y  = !s3_z_q[16];
      div_in.side.flip_y = 1'b1;
    end else if (ay == adiv && ypos) begin
      div_in.side.face   = FACE_DOWN;
      div_in.mag_x       = ax;
      div_in.side.inv_x  = s3_x_q[16];
      div_in.mag_y       = az;
      div_in.side.inv_y  = s3_z_q[16];
      div_in.side.flip_y = 1'b1;
    end else if (az == adiv && zpos) begin
      div_in.side.face  = FACE_FRONT;
      div_in.mag_x      = ax;
      div_in.side.inv_x = s3_x_q[16];
    end else begin
      div_in.side.face  = FACE_BACK;
      div_in.mag_x      = ax;
      div_in.side.inv_x = !s3_x_q[16];
    end
  end

  logic        s4_v_q;
  e2c_div_in_t s4_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s4_v_q <= 1'b0;
    end else if (en) begin
      s4_v_q <= s3_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      s4_q <= div_in;
    end
  end

  // ---------------- Divider ----------------
  logic         dv_valid;
  e2c_div_out_t dv_out;

  e2c_div u_div (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .en_i    (en),
    .valid_i (s4_v_q),
    .din_i   (s4_q),
    .valid_o (dv_valid),
    .dout_o  (dv_out)
  );

  // ---------------- Output stage: texel coordinates ----------------
  localparam logic [12:0] FW_M1 = 13'(FACE_WIDTH - 1);
  localparam logic [12:0] FH_M1 = 13'(FACE_HEIGHT - 1);

  logic [16:0] ux, uy;
  logic [29:0] px, py;
  logic [8:0]  cx, cy;
  e2c_out_t    out_d;

  assign ux = dv_out.side.inv_x ? 17'(17'd32768 - {1'b0, dv_out.quo_x})
                                : 17'(17'd32768 + {1'b0, dv_out.quo_x});
  assign uy = dv_out.side.inv_y ? 17'(17'd32768 - {1'b0, dv_out.quo_y})
                                : 17'(17'd32768 + {1'b0, dv_out.quo_y});
  assign px = ux * FW_M1;
  assign py = uy * FH_M1;
  assign cx = px[24:16];
  assign cy = py[24:16];

  assign out_d.face   = dv_out.side.face;
  assign out_d.face_x = cx;
  assign out_d.face_y = dv_out.side.flip_y ? 9'(FH_M1[8:0] - cy) : cy;

  e2c_out_t out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (en) begin
      out_valid_q <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      out_q <= out_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  // ---------------- Checks ----------------
  `ASSERT_ALWAYS(a_stall_follows_output, clk_i, rst_ni,
                 in_stall_o == (out_valid_q && out_stall_i), "stall path mismatch")
  `ASSERT_NEVER(a_face_code, clk_i, rst_ni,
                out_valid_o && (out_data_o.face > 3'd5), "face code out of range")
  `ASSERT_NEVER(a_mag_over_divisor, clk_i, rst_ni,
                s4_v_q && ((s4_q.mag_x > {1'b0, s4_q.divisor}) ||
                (s4_q.mag_y > {1'b0, s4_q.divisor}) || (s4_q.divisor == 15'd0)),
                "divider operand out of range")

endmodule
